@@ src/rtdct_pkg.sv @@
// Shared constants, payload types and coefficient tables for the RTD temperature converter.
`timescale 1ns / 1ps
package rtdct_pkg;

	localparam int CodeW = 15;
	localparam int RefW  = 16;
	localparam int TempW = 17;
	localparam int ProdW = 31;
	localparam int AddrW = 3;
	localparam int DataW = 32;

	// Quadratic branch, units of 2^-16 degree
	localparam int AfW = 28;
	localparam logic [ProdW-1:0] RNominalP = 31'd32768000;
	localparam logic [AfW-1:0] CvdAf = 28'd221761341;
	localparam logic [AfW-1:0] CvdK  = 28'd226964502;
	localparam int KdW = AfW + ProdW;
	localparam int SW  = KdW + 1;

	// Integer square root over the radicand
	localparam int SqrtW     = 56;
	localparam int SqrtSteps = 28;
	localparam logic [SqrtW-1:0] CvdAfSq = CvdAf * CvdAf;

	// floor(P / 5) by reciprocal, exact for P below 2^25
	localparam int RecipInW  = 25;
	localparam int RecipW    = 25;
	localparam int RecipShift = 27;
	localparam logic [RecipW-1:0] RecipFive = 25'd26843546;
	localparam int XW = 23;

	// Horner polynomial
	localparam int PolySteps = 5;
	localparam int AccW      = 36;
	localparam int PolyProdW = AccW + XW + 1;
	localparam int PolyDelay = SqrtSteps - 2 * PolySteps;
	localparam logic signed [AccW-1:0] PolyInit = 36'sd10983739;
	localparam logic signed [AccW-1:0] PolyAdd [PolySteps] = '{
		-36'sd2030799173,
		-36'sd1358400238,
		36'sd2843227118,
		36'sd9546853306,
		-36'sd15861023
	};
	localparam int PolyShift [PolySteps] = '{16, 24, 24, 24, 32};

	// Temperature before rounding, units of 2^-16 degree
	localparam int T16W = 30;
	localparam int RndW = T16W + 1;
	localparam int RndShift = 10;
	localparam int T64W = RndW - RndShift;
	localparam logic signed [T64W-1:0] TempMax = 21'sd65535;
	localparam logic signed [T64W-1:0] TempMin = -21'sd16384;

	typedef struct packed {
		logic [CodeW-1:0] rtd_code;
	} sample_t;

	typedef struct packed {
		logic signed [TempW-1:0] temperature;
		logic                    used_polynomial;
		logic                    saturated;
	} result_t;

	typedef struct packed {
		logic ge;   // resistance at or above nominal
		logic neg;  // radicand negative, no real root
	} side_t;

endpackage

@@ src/rtdct_stream_if.sv @@
// Valid/ready stream channel carrying one payload per request.
`timescale 1ns / 1ps
interface rtdct_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ src/rtd_code_to_temperature_unit.sv @@
// Top level of the RTD code to temperature converter: front end, branch select, output.
//
// Usage: one sample request on the sample channel (rtd_code, 15 bits) gives one result
// request on the result channel (temperature in signed 1/64 degree C, used_polynomial,
// saturated). The reference resistor in ohms sits in an APB register at byte address 0
// (reset 4300); write it only while no sample is in flight.
// Throughput: one sample per cycle when the receiver takes every result; the 28-stage
// square root sets the depth.
// The quadratic branch (square root) and the polynomial branch run side by side on every
// sample and the choice is made in the last stage.
// Reset: arst_n clears all valid bits, the output valid among them; the reference register
// returns to 4300. Payload registers, the output payload included, are not reset.
// Stall: when a result waits and result.ready is low, the whole pipeline holds and
// sample.ready drops; nothing is lost or repeated, and it resumes the cycle ready returns.
`timescale 1ns / 1ps
module rtd_code_to_temperature_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	rtdct_stream_if.sink                  sample,
	rtdct_stream_if.source                result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [rtdct_pkg::AddrW-1:0]   paddr,
	input  logic [rtdct_pkg::DataW-1:0]   pwdata,
	output logic [rtdct_pkg::DataW-1:0]   prdata,
	output logic                          pready
);
	localparam int N = rtdct_pkg::SqrtSteps;

	logic [rtdct_pkg::RefW-1:0] ref_ohms;
	logic                       en;

	// stage 1: resistance product
	logic                         vld_s1;
	logic [rtdct_pkg::ProdW-1:0]  p_s1;
	// stage 2: K*d and reciprocal product for x = P/5
	logic                                          vld_s2;
	logic                                          ge_s2;
	logic [rtdct_pkg::KdW-1:0]                     kd_s2;
	logic [rtdct_pkg::RecipInW+rtdct_pkg::RecipW-1:0] xm_s2;
	// stage 3: radicand and x
	logic                         vld_s3;
	rtdct_pkg::side_t             side_s3;
	logic [rtdct_pkg::SqrtW-1:0]  rad_s3;
	logic [rtdct_pkg::XW-1:0]     x_s3;
	logic signed [rtdct_pkg::SW-1:0] s_full;
	// side band alongside the square root
	logic             vld_sd  [N];
	rtdct_pkg::side_t side_sd [N];

	logic [rtdct_pkg::AfW-1:0]         root;
	logic signed [rtdct_pkg::T16W-1:0] t16_poly;

	// output register
	logic                 res_vld_q;
	rtdct_pkg::result_t   res_q;

	logic signed [rtdct_pkg::T16W-1:0] t16;
	logic signed [rtdct_pkg::RndW-1:0] rnd;
	logic signed [rtdct_pkg::T64W-1:0] t64;
	rtdct_pkg::result_t                res_d;

	rtdct_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.ref_ohms (ref_ohms)
	);

	// Advance everything whenever the output register is free or being drained.
	assign en           = !res_vld_q || result.ready;
	assign sample.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= sample.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1  <= rtdct_pkg::ProdW'(sample.data.rtd_code) * rtdct_pkg::ProdW'(ref_ohms);
			ge_s2 <= p_s1 >= rtdct_pkg::RNominalP;
			// d wraps below nominal; that case takes the polynomial
			kd_s2 <= rtdct_pkg::CvdK * (p_s1 - rtdct_pkg::RNominalP);
			xm_s2 <= p_s1[rtdct_pkg::RecipInW-1:0] * rtdct_pkg::RecipFive;
			side_s3.ge  <= ge_s2;
			side_s3.neg <= s_full < 0;
			rad_s3      <= s_full[rtdct_pkg::SqrtW-1:0];
			x_s3        <= xm_s2[rtdct_pkg::RecipShift +: rtdct_pkg::XW];
		end
	end

	// S = AF^2 - K*d, wide enough to show a negative radicand
	assign s_full = $signed({{(rtdct_pkg::SW - rtdct_pkg::SqrtW){1'b0}}, rtdct_pkg::CvdAfSq})
		- $signed({1'b0, kd_s2});

	rtdct_sqrt u_sqrt (
		.clk      (clk),
		.en       (en),
		.radicand (rad_s3),
		.root     (root)
	);

	rtdct_poly u_poly (
		.clk (clk),
		.en  (en),
		.x   (x_s3),
		.t16 (t16_poly)
	);

	// Carry valid and branch flags alongside the root stages.
	for (genvar k = 0; k < N; k++) begin : g_side
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sd[k] <= 1'b0;
			end else if (en) begin
				vld_sd[k] <= (k == 0) ? vld_s3 : vld_sd[k == 0 ? 0 : k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_sd[k] <= (k == 0) ? side_s3 : side_sd[k == 0 ? 0 : k-1];
			end
		end
	end

	// Select branch, round to 1/64 degree, saturate.
	always_comb begin
		if (side_sd[N-1].ge) begin
			t16 = $signed({{(rtdct_pkg::T16W - rtdct_pkg::AfW){1'b0}},
				rtdct_pkg::CvdAf - root});
		end else begin
			t16 = t16_poly;
		end
		rnd = rtdct_pkg::RndW'(t16) + rtdct_pkg::RndW'(512);
		t64 = rtdct_pkg::T64W'(rnd >>> rtdct_pkg::RndShift);

		res_d.used_polynomial = !side_sd[N-1].ge;
		res_d.saturated       = 1'b0;
		res_d.temperature     = rtdct_pkg::TempW'(t64);
		if (side_sd[N-1].ge && side_sd[N-1].neg) begin
			// no real root: far above range
			res_d.temperature     = rtdct_pkg::TempW'(rtdct_pkg::TempMax);
			res_d.used_polynomial = 1'b1;
			res_d.saturated       = 1'b1;
		end else if (t64 > rtdct_pkg::TempMax) begin
			res_d.temperature = rtdct_pkg::TempW'(rtdct_pkg::TempMax);
			res_d.saturated   = 1'b1;
		end else if (t64 < rtdct_pkg::TempMin) begin
			res_d.temperature = rtdct_pkg::TempW'(rtdct_pkg::TempMin);
			res_d.saturated   = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (en) begin
			res_vld_q <= vld_sd[N-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q <= res_d;
		end
	end

	assign result.valid = res_vld_q;
	assign result.data  = res_q;
endmodule

@@ src/rtdct_cfg.sv @@
// APB register holding the reference resistor value.
`timescale 1ns / 1ps
module rtdct_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [rtdct_pkg::AddrW-1:0]   paddr,
	input  logic [rtdct_pkg::DataW-1:0]   pwdata,
	output logic [rtdct_pkg::DataW-1:0]   prdata,
	output logic                          pready,
	output logic [rtdct_pkg::RefW-1:0]    ref_ohms
);
	logic [rtdct_pkg::RefW-1:0] ref_q;
	logic                       hit;

	assign hit    = !paddr[rtdct_pkg::AddrW-1];
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q <= 16'd4300;
		end else if (psel && penable && pwrite && pready && hit) begin
			ref_q <= pwdata[rtdct_pkg::RefW-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (hit) begin
			prdata = {{(rtdct_pkg::DataW - rtdct_pkg::RefW){1'b0}}, ref_q};
		end
	end

	assign ref_ohms = ref_q;
endmodule

@@ src/rtdct_sqrt.sv @@
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
module rtdct_sqrt (
	input  logic                          clk,
	input  logic                          en,
	input  logic [rtdct_pkg::SqrtW-1:0]   radicand,
	output logic [rtdct_pkg::AfW-1:0]     root
);
	localparam int W = rtdct_pkg::SqrtW;
	localparam int N = rtdct_pkg::SqrtSteps;

	logic [W-1:0] rem_s  [N];
	logic [W-1:0] root_s [N];

	for (genvar k = 0; k < N; k++) begin : g_step
		localparam logic [W-1:0] Bit = W'(1) << (2 * (N - 1 - k));
		logic [W-1:0] rem_in, root_in, trial;

		if (k == 0) begin : g_first
			assign rem_in  = radicand;
			assign root_in = '0;
		end else begin : g_next
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
		end

		assign trial = root_in + Bit;

		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_in >= trial) begin
					rem_s[k]  <= rem_in - trial;
					root_s[k] <= (root_in >> 1) + Bit;
				end else begin
					rem_s[k]  <= rem_in;
					root_s[k] <= root_in >> 1;
				end
			end
		end
	end

	assign root = root_s[N-1][rtdct_pkg::AfW-1:0];
endmodule

@@ src/rtdct_poly.sv @@
// Pipelined Horner evaluation of the below-zero polynomial, delayed to match the root.
`timescale 1ns / 1ps
module rtdct_poly (
	input  logic                                clk,
	input  logic                                en,
	input  logic [rtdct_pkg::XW-1:0]            x,
	output logic signed [rtdct_pkg::T16W-1:0]   t16
);
	localparam int N = rtdct_pkg::PolySteps;

	logic signed [rtdct_pkg::PolyProdW-1:0] prod_s [N];
	logic signed [rtdct_pkg::AccW-1:0]      acc_s  [N];
	logic [rtdct_pkg::XW-1:0]               xa_s   [N];
	logic [rtdct_pkg::XW-1:0]               xb_s   [N-1];
	logic signed [rtdct_pkg::T16W-1:0]      dly_s  [rtdct_pkg::PolyDelay];

	for (genvar i = 0; i < N; i++) begin : g_step
		logic signed [rtdct_pkg::AccW-1:0] acc_in;
		logic [rtdct_pkg::XW-1:0]          x_in;

		if (i == 0) begin : g_first
			assign acc_in = rtdct_pkg::PolyInit;
			assign x_in   = x;
		end else begin : g_next
			assign acc_in = acc_s[i-1];
			assign x_in   = xb_s[i-1];
		end

		// multiply, then shift and add the next coefficient
		always_ff @(posedge clk) begin
			if (en) begin
				prod_s[i] <= acc_in * $signed({1'b0, x_in});
				xa_s[i]   <= x_in;
				acc_s[i]  <= rtdct_pkg::PolyAdd[i]
					+ rtdct_pkg::AccW'(prod_s[i] >>> rtdct_pkg::PolyShift[i]);
			end
		end

		if (i < N - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					xb_s[i] <= xa_s[i];
				end
			end
		end
	end

	for (genvar j = 0; j < rtdct_pkg::PolyDelay; j++) begin : g_dly
		if (j == 0) begin : g_head
			always_ff @(posedge clk) begin
				if (en) begin
					dly_s[j] <= rtdct_pkg::T16W'(acc_s[N-1]);
				end
			end
		end else begin : g_tail
			always_ff @(posedge clk) begin
				if (en) begin
					dly_s[j] <= dly_s[j-1];
				end
			end
		end
	end

	assign t16 = dly_s[rtdct_pkg::PolyDelay-1];
endmodule

@@ dv/rtd_code_to_temperature_unit_tb.sv @@
// Self-checking testbench for the RTD code to temperature converter.
`timescale 1ns / 1ps
module rtd_code_to_temperature_unit_tb;

	// Register map: the reference resistor sits at byte address 0
	localparam logic [rtdct_pkg::AddrW-1:0] RegReferenceOhms = '0;
	localparam int RefReset = 4300;
	localparam int DrainCycles = 40;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [rtdct_pkg::AddrW-1:0] paddr;
	logic [rtdct_pkg::DataW-1:0] pwdata;
	logic [rtdct_pkg::DataW-1:0] prdata;
	logic pready;

	rtdct_stream_if #(.payload_t(rtdct_pkg::sample_t)) sample_ch ();
	rtdct_stream_if #(.payload_t(rtdct_pkg::result_t)) result_ch ();

	rtd_code_to_temperature_unit u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.sample  (sample_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Predictor copy of the reference register
	logic [rtdct_pkg::RefW-1:0] ref_ohms_model;
	// Temperatures still owed by the block, oldest first
	rtdct_pkg::result_t pending_temps[$];
	int unsigned mismatch_count;
	int unsigned checked_count;
	// Idle control: when clear, neither side inserts gaps
	bit idle_on;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	task automatic report(input string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// Floor integer square root, bit by bit
	function automatic longint unsigned root_floor(input longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// Expected conversion of one code under the current reference resistor
	function automatic rtdct_pkg::result_t convert_code(
			input logic [rtdct_pkg::CodeW-1:0] code,
			input logic [rtdct_pkg::RefW-1:0] ref_ohms);
		longint prod;
		longint rad;
		longint t16;
		longint t64;
		longint x;
		longint acc;
		rtdct_pkg::result_t r;
		prod = longint'(code) * longint'(ref_ohms);
		r.used_polynomial = 1'b0;
		r.saturated = 1'b0;
		if (prod >= 64'sd32768000) begin
			rad = 64'sd221761341 * 64'sd221761341
				- 64'sd226964502 * (prod - 64'sd32768000);
			// No real root: far above range, reported as a clamped polynomial result
			if (rad < 0) begin
				r.temperature = 17'sd65535;
				r.used_polynomial = 1'b1;
				r.saturated = 1'b1;
				return r;
			end
			t16 = 64'sd221761341 - longint'(root_floor(rad));
		end else begin
			x = prod / 5;
			acc = 64'sd10983739;
			acc = -64'sd2030799173 + ((acc * x) >>> 16);
			acc = -64'sd1358400238 + ((acc * x) >>> 24);
			acc = 64'sd2843227118 + ((acc * x) >>> 24);
			acc = 64'sd9546853306 + ((acc * x) >>> 24);
			t16 = -64'sd15861023 + ((acc * x) >>> 32);
			r.used_polynomial = 1'b1;
		end
		t64 = (t16 + 512) >>> 10;
		if (t64 > 65535) begin
			t64 = 65535;
			r.saturated = 1'b1;
		end else if (t64 < -16384) begin
			t64 = -16384;
			r.saturated = 1'b1;
		end
		r.temperature = t64[rtdct_pkg::TempW-1:0];
		return r;
	endfunction

	// Gap length: mostly none or short, now and then long
	function automatic int pick_gap();
		if (!idle_on)
			return 0;
		case ($urandom_range(0, 19))
			0: return $urandom_range(10, 40);
			1, 2, 3, 4, 5: return $urandom_range(1, 3);
			default: return 0;
		endcase
	endfunction

	// Send one sample request and log its expected temperature at acceptance
	task automatic send_code(input logic [rtdct_pkg::CodeW-1:0] code);
		int gap;
		rtdct_pkg::sample_t s;
		gap = pick_gap();
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s.rtd_code = code;
		sample_ch.valid <= 1'b1;
		sample_ch.data <= s;
		do @(posedge clk); while (!sample_ch.ready);
		pending_temps.push_back(convert_code(code, ref_ohms_model));
	endtask

	// Drop valid and hold until every owed result is back
	task automatic wait_idle();
		sample_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_temps.size() != 0)
			@(posedge clk);
	endtask

	// APB write of the reference resistor, only with the pipeline empty
	task automatic write_reference(input logic [rtdct_pkg::RefW-1:0] ohms);
		wait_idle();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= RegReferenceOhms;
		pwdata <= rtdct_pkg::DataW'(ohms);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		ref_ohms_model = ohms;
	endtask

	// Code at the quadratic/polynomial boundary for a given reference
	function automatic int unsigned boundary_code(input logic [rtdct_pkg::RefW-1:0] ohms);
		int unsigned c;
		if (ohms == 0)
			return 0;
		c = (32768000 + ohms - 1) / ohms;
		return (c > 32767) ? 32767 : c;
	endfunction

	// Result checker: compare every accepted result with the oldest expectation
	always @(posedge clk) begin
		rtdct_pkg::result_t exp_r;
		rtdct_pkg::result_t got;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got = result_ch.data;
			if (pending_temps.size() == 0) begin
				report($sformatf("unexpected result temp=%0d", got.temperature));
			end else begin
				exp_r = pending_temps.pop_front();
				checked_count++;
				if (got.temperature !== exp_r.temperature)
					report($sformatf("temperature got %0d want %0d",
						got.temperature, exp_r.temperature));
				if (got.used_polynomial !== exp_r.used_polynomial)
					report($sformatf("used_polynomial got %b want %b",
						got.used_polynomial, exp_r.used_polynomial));
				if (got.saturated !== exp_r.saturated)
					report($sformatf("saturated got %b want %b",
						got.saturated, exp_r.saturated));
			end
		end
	end

	// Receiver back-pressure: mostly ready, short stalls, a few long ones
	always @(posedge clk) begin
		int stall;
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else if (!idle_on) begin
			result_ch.ready <= 1'b1;
		end else begin
			case ($urandom_range(0, 29))
				0: stall = $urandom_range(10, 40);
				1, 2, 3, 4, 5, 6: stall = $urandom_range(1, 3);
				default: stall = 0;
			endcase
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
		end
	end

	// Directed: code extremes, branch boundary, reset reference and zero
	task automatic test_directed();
		int unsigned b;
		idle_on = 1'b0;
		send_code(15'd0);
		send_code(15'h7FFF);
		b = boundary_code(ref_ohms_model);
		send_code(rtdct_pkg::CodeW'(b - 1));
		send_code(rtdct_pkg::CodeW'(b));
		send_code(15'h5555);
		send_code(15'h2AAA);
		send_code(15'd1);
		idle_on = 1'b1;
		send_code(15'd9000);
		send_code(15'd20000);
	endtask

	// Extreme references: no real root, high saturation, zero, minimum
	task automatic test_reference_extremes();
		int unsigned b;
		write_reference(16'hFFFF);
		send_code(15'h7FFF);
		send_code(15'd600);
		send_code(15'd4000);
		b = boundary_code(ref_ohms_model);
		send_code(rtdct_pkg::CodeW'(b - 1));
		send_code(rtdct_pkg::CodeW'(b));
		write_reference(16'd0);
		send_code(15'h7FFF);
		send_code(15'd0);
		write_reference(16'd1);
		send_code(15'h7FFF);
		send_code(15'd12345);
		write_reference(16'd12000);
		send_code(15'd13000);
		send_code(15'd20000);
		send_code(15'h7FFF);
	endtask

	// Random codes under a spread of references, some bursts without idling
	task automatic test_random();
		int unsigned b;
		logic [rtdct_pkg::RefW-1:0] ohms;
		for (int ph = 0; ph < 12; ph++) begin
			case (ph % 4)
				0: ohms = rtdct_pkg::RefW'(RefReset);
				1: ohms = rtdct_pkg::RefW'($urandom_range(0, 65535));
				2: ohms = rtdct_pkg::RefW'($urandom_range(1000, 8000));
				default: ohms = rtdct_pkg::RefW'($urandom_range(1, 2000));
			endcase
			write_reference(ohms);
			idle_on = (ph % 3) != 2;
			b = boundary_code(ohms);
			for (int i = 0; i < 75; i++) begin
				if ($urandom_range(0, 3) == 0 && b > 8)
					send_code(rtdct_pkg::CodeW'($urandom_range(b - 8,
						(b + 8 > 32767) ? 32767 : b + 8)));
				else
					send_code(rtdct_pkg::CodeW'($urandom_range(0, 32767)));
				// Hold the sender once until the pipeline drains
				if (ph == 5 && i == 40)
					wait_idle();
			end
		end
		idle_on = 1'b1;
		write_reference(rtdct_pkg::RefW'(RefReset));
		for (int i = 0; i < 40; i++)
			send_code(rtdct_pkg::CodeW'($urandom_range(0, 32767)));
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		sample_ch.valid = 1'b0;
		sample_ch.data = '0;
		mismatch_count = 0;
		checked_count = 0;
		idle_on = 1'b1;
		ref_ohms_model = rtdct_pkg::RefW'(RefReset);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_reference_extremes();
		test_random();

		wait_idle();
		repeat (DrainCycles) @(posedge clk);
		if (mismatch_count == 0)
			$display("rtd_code_to_temperature_unit verification clean");
		else
			$display("rtd_code_to_temperature_unit verification failed");
		$finish;
	end

	// Watchdog
	initial begin
		#20ms;
		$display("rtd_code_to_temperature_unit verification failed");
		$finish;
	end

endmodule
